// ===== sv/tbbe_pkg.sv =====
// Shared widths, types and the binomial table for the Bernstein basis evaluator.
`timescale 1ns / 1ps

package tbbe_pkg;

    // Field widths
    localparam int DEG_W      = 3;
    localparam int MAX_DEGREE = 7;
    localparam int SAMPLE_W   = 8;
    localparam int FRAC_BITS  = 16;
    localparam int BINOM_W    = 6;

    // Exact rational per direction: num / den, both below 2^NUM_W
    localparam int NUM_W = MAX_DEGREE * SAMPLE_W;
    localparam int REM_W = NUM_W + 1;

    // Per-direction factor in Q1.Q_FRAC, quotient carries one guard bit for rounding
    localparam int Q_FRAC   = 31;
    localparam int F_W      = Q_FRAC + 1;
    localparam int QUO_BITS = F_W + 1;

    // Product and final rounding
    localparam int PROD_W      = 2 * F_W;
    localparam int ROUND_SHIFT = 2 * Q_FRAC - FRAC_BITS;
    localparam int VAL_W       = FRAC_BITS + 1;

    // Factor unit pipeline depth: power stages, divide steps, rounding register
    localparam int FACTOR_LAT = MAX_DEGREE + QUO_BITS + 1;

    // Output queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SAMPLE_W-1:0] DIVS_RESET = SAMPLE_W'(8);
    localparam logic [VAL_W-1:0]    VAL_ONE    = VAL_W'(1) << FRAC_BITS;
    localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W+1)'(1) << (ROUND_SHIFT - 1);

    // C(n,k), zero above the diagonal
    localparam logic [BINOM_W-1:0] BINOM_TABLE [8][8] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    // One direction of a query
    typedef struct packed {
        logic [DEG_W-1:0]    deg;
        logic [DEG_W-1:0]    idx;
        logic [SAMPLE_W-1:0] smp;
        logic [BINOM_W-1:0]  coef;
    } tbbe_dir_t;

    // One result item
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             err;
    } tbbe_result_t;

endpackage

// ===== sv/tensor_bernstein_basis_eval_unit.sv =====
// Top level of the tensor-product Bernstein basis evaluator.
`timescale 1ns / 1ps

// Channel   Ports                        Direction  Carries
// -------   ---------------------------  ---------  ------------------------------------
// query     s_valid / s_ready / s_*      in         degrees, basis indices, sample indices
// result    m_valid / m_ready / m_*      out        basis_value (Q1.16), range_error
// config    cfg_valid / cfg_ready        in         sample_divisions (8 bits)
//
// One item per cycle sustained while the output queue has room; an accepted item loads the
// input register, then passes 7 power stages, 33 divide stages, factor rounding, multiply,
// final round and the output queue write before m_valid rises.
// Reset is synchronous, active low; it clears valid bits, queue pointers and sets divisions to 8.
// The whole pipeline advances on one enable, high while the two-entry output queue has room;
// s_ready equals that enable and comes from a register, not from m_ready.
// cfg_ready is always high; the register is meant to change only while no item is in flight.

module tensor_bernstein_basis_eval_unit import tbbe_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DEG_W-1:0]    s_degree_u,
    input  logic [DEG_W-1:0]    s_degree_v,
    input  logic [DEG_W-1:0]    s_basis_u,
    input  logic [DEG_W-1:0]    s_basis_v,
    input  logic [SAMPLE_W-1:0] s_sample_u,
    input  logic [SAMPLE_W-1:0] s_sample_v,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VAL_W-1:0]    m_basis_value,
    output logic                m_range_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    // Configuration
    logic [SAMPLE_W-1:0] divs_reg, divs_next;

    // Pipeline enable
    logic en;

    // Input stage
    logic      in_vld_reg, in_vld_next;
    logic      in_bad_reg, in_bad_next;
    tbbe_dir_t in_u_reg, in_u_next;
    tbbe_dir_t in_v_reg, in_v_next;

    // Valid / range flag travel alongside the factor units
    logic vld_pipe_reg [FACTOR_LAT];
    logic bad_pipe_reg [FACTOR_LAT];

    logic [F_W-1:0] f_u;
    logic [F_W-1:0] f_v;

    // Multiply stage
    logic              mul_vld_reg;
    logic              mul_bad_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // Round stage
    logic         rnd_vld_reg;
    tbbe_result_t rnd_data_reg, rnd_data_next;
    logic [PROD_W:0] rnd_sum;

    tbbe_result_t q_data;

    // ---------------- configuration register ----------------
    assign cfg_ready = 1'b1;
    assign divs_next = (cfg_valid && cfg_ready) ? cfg_data : divs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divs_reg <= DIVS_RESET;
        end else begin
            divs_reg <= divs_next;
        end
    end

    assign s_ready = en;

    // ---------------- input stage: range check, binomial lookup ----------------
    always_comb begin
        in_vld_next = s_valid;
        in_bad_next = (divs_reg == '0)
                   || (s_basis_u > s_degree_u) || (s_basis_v > s_degree_v)
                   || (s_sample_u > divs_reg)  || (s_sample_v > divs_reg);
        in_u_next.deg  = s_degree_u;
        in_u_next.idx  = s_basis_u;
        in_u_next.smp  = s_sample_u;
        in_u_next.coef = BINOM_TABLE[s_degree_u][s_basis_u];
        in_v_next.deg  = s_degree_v;
        in_v_next.idx  = s_basis_v;
        in_v_next.smp  = s_sample_v;
        in_v_next.coef = BINOM_TABLE[s_degree_v][s_basis_v];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_bad_reg <= in_bad_next;
            in_u_reg   <= in_u_next;
            in_v_reg   <= in_v_next;
        end
    end

    // ---------------- per-direction factors ----------------
    tbbe_factor u_factor_u (
        .aclk   (aclk),
        .en     (en),
        .divs   (divs_reg),
        .dir_in (in_u_reg),
        .f_out  (f_u)
    );

    tbbe_factor u_factor_v (
        .aclk   (aclk),
        .en     (en),
        .divs   (divs_reg),
        .dir_in (in_v_reg),
        .f_out  (f_v)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FACTOR_LAT; k++) begin
                vld_pipe_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_pipe_reg[0] <= in_vld_reg;
            for (int k = 1; k < FACTOR_LAT; k++) begin
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bad_pipe_reg[0] <= in_bad_reg;
            for (int k = 1; k < FACTOR_LAT; k++) begin
                bad_pipe_reg[k] <= bad_pipe_reg[k-1];
            end
        end
    end

    // ---------------- product: Q1.31 x Q1.31 -> Q2.62 ----------------
    assign prod_next = f_u * f_v;

    // ---------------- round to Q1.16, halves up; zero on range error ----------------
    assign rnd_sum = {1'b0, prod_reg} + ROUND_HALF;

    always_comb begin
        rnd_data_next.err   = mul_bad_reg;
        rnd_data_next.value = mul_bad_reg ? '0 : rnd_sum[ROUND_SHIFT +: VAL_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
        end else if (en) begin
            mul_vld_reg <= vld_pipe_reg[FACTOR_LAT-1];
            rnd_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_bad_reg  <= bad_pipe_reg[FACTOR_LAT-1];
            prod_reg     <= prod_next;
            rnd_data_reg <= rnd_data_next;
        end
    end

    // ---------------- output queue ----------------
    tbbe_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (rnd_vld_reg),
        .push_data  (rnd_data_reg),
        .has_room   (en),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .pop_data   (q_data)
    );

    assign m_basis_value = q_data.value;
    assign m_range_error = q_data.err;

`ifndef SYNTH
    // Out-of-range items always carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_basis_value == '0)
        else $error("range error item with nonzero value");

    // Value never exceeds 1.0
    a_val_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_basis_value <= VAL_ONE)
        else $error("basis value above one");

    // Input only stalls while results are queued
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output queue");

    // Stalled pipeline holds its last stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(rnd_vld_reg) && $stable(rnd_data_reg))
        else $error("round stage changed during stall");
`endif

endmodule

// ===== sv/tbbe_factor.sv =====
// One direction: pipelined power products, then a restoring divide, one quotient bit per stage.
`timescale 1ns / 1ps

module tbbe_factor import tbbe_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] divs,
    input  tbbe_dir_t           dir_in,
    output logic [F_W-1:0]      f_out
);

    // Power stages: num *= s, (d-s) or 1, den *= d or 1, one factor per stage
    tbbe_dir_t                   pw_ctl_reg  [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_num_reg  [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_den_reg  [MAX_DEGREE];
    tbbe_dir_t                   pw_ctl_prev [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_num_prev [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_den_prev [MAX_DEGREE];
    logic [SAMPLE_W-1:0]         mul_num     [MAX_DEGREE];
    logic [SAMPLE_W-1:0]         mul_den     [MAX_DEGREE];
    logic [NUM_W+SAMPLE_W-1:0]   num_prod    [MAX_DEGREE];
    logic [NUM_W+SAMPLE_W-1:0]   den_prod    [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_num_next [MAX_DEGREE];
    logic [NUM_W-1:0]            pw_den_next [MAX_DEGREE];

    // Divide stages
    logic [REM_W-1:0]    dv_rem_reg  [QUO_BITS];
    logic [NUM_W-1:0]    dv_den_reg  [QUO_BITS];
    logic [QUO_BITS-1:0] dv_quo_reg  [QUO_BITS];
    logic [REM_W-1:0]    dv_rem_prev [QUO_BITS];
    logic [NUM_W-1:0]    dv_den_prev [QUO_BITS];
    logic [QUO_BITS-1:0] dv_quo_prev [QUO_BITS];
    logic                dv_ge       [QUO_BITS];
    logic [REM_W-1:0]    dv_diff     [QUO_BITS];
    logic [REM_W-1:0]    dv_rem_next [QUO_BITS];
    logic [QUO_BITS-1:0] dv_quo_next [QUO_BITS];

    logic [QUO_BITS:0] f_inc;
    logic [F_W-1:0]    f_reg;
    logic [F_W-1:0]    f_next;

    always_comb begin
        pw_ctl_prev[0] = dir_in;
        pw_num_prev[0] = NUM_W'(dir_in.coef);
        pw_den_prev[0] = NUM_W'(1);
        for (int k = 1; k < MAX_DEGREE; k++) begin
            pw_ctl_prev[k] = pw_ctl_reg[k-1];
            pw_num_prev[k] = pw_num_reg[k-1];
            pw_den_prev[k] = pw_den_reg[k-1];
        end
        for (int k = 0; k < MAX_DEGREE; k++) begin
            if (DEG_W'(k) < pw_ctl_prev[k].idx) begin
                mul_num[k] = pw_ctl_prev[k].smp;
            end else if (DEG_W'(k) < pw_ctl_prev[k].deg) begin
                mul_num[k] = divs - pw_ctl_prev[k].smp;
            end else begin
                mul_num[k] = SAMPLE_W'(1);
            end
            mul_den[k]     = (DEG_W'(k) < pw_ctl_prev[k].deg) ? divs : SAMPLE_W'(1);
            num_prod[k]    = pw_num_prev[k] * mul_num[k];
            den_prod[k]    = pw_den_prev[k] * mul_den[k];
            pw_num_next[k] = num_prod[k][NUM_W-1:0];
            pw_den_next[k] = den_prod[k][NUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < MAX_DEGREE; k++) begin
                pw_ctl_reg[k] <= pw_ctl_prev[k];
                pw_num_reg[k] <= pw_num_next[k];
                pw_den_reg[k] <= pw_den_next[k];
            end
        end
    end

    // Restoring divide: quotient of num * 2^(QUO_BITS-1) / den, num <= den
    always_comb begin
        dv_rem_prev[0] = {1'b0, pw_num_reg[MAX_DEGREE-1]};
        dv_den_prev[0] = pw_den_reg[MAX_DEGREE-1];
        dv_quo_prev[0] = '0;
        for (int k = 1; k < QUO_BITS; k++) begin
            dv_rem_prev[k] = dv_rem_reg[k-1];
            dv_den_prev[k] = dv_den_reg[k-1];
            dv_quo_prev[k] = dv_quo_reg[k-1];
        end
        for (int k = 0; k < QUO_BITS; k++) begin
            dv_ge[k]       = (dv_rem_prev[k] >= {1'b0, dv_den_prev[k]});
            dv_diff[k]     = dv_ge[k] ? (dv_rem_prev[k] - {1'b0, dv_den_prev[k]})
                                      : dv_rem_prev[k];
            dv_rem_next[k] = {dv_diff[k][REM_W-2:0], 1'b0};
            dv_quo_next[k] = {dv_quo_prev[k][QUO_BITS-2:0], dv_ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_BITS; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_den_reg[k] <= dv_den_prev[k];
                dv_quo_reg[k] <= dv_quo_next[k];
            end
        end
    end

    // Round to nearest, halves up: drop the guard bit
    assign f_inc  = {1'b0, dv_quo_reg[QUO_BITS-1]} + (QUO_BITS+1)'(1);
    assign f_next = f_inc[F_W:1];

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
        end
    end

    assign f_out = f_reg;

endmodule

// ===== sv/tbbe_out_queue.sv =====
// Two-entry result queue that decouples the pipeline stall from the output ready.
`timescale 1ns / 1ps

module tbbe_out_queue import tbbe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    input  tbbe_result_t push_data,
    output logic         has_room,
    output logic         m_valid,
    input  logic         m_ready,
    output tbbe_result_t pop_data
);

    tbbe_result_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign has_room = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign m_valid  = (count_reg != '0);
    assign push     = push_valid && has_room;
    assign pop      = m_valid && m_ready;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
